// ===== sv/gaussian_polar_sampler_top_assert.svh =====
// assertion macros for the gaussian polar sampler checker
// expects i_clk and i_rst_n in the scope of use
`ifndef GAUSSIAN_POLAR_SAMPLER_TOP_ASSERT_SVH
`define GAUSSIAN_POLAR_SAMPLER_TOP_ASSERT_SVH

// same-cycle implication
`define GPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/gps_pkg.sv =====
// shared types and constants of the gaussian polar sampler
// no dependencies
package gps_pkg;

    localparam int M_W      = 31;  // |v| in q.30
    localparam int SQ_W     = 62;  // square of |v|
    localparam int S_W      = 60;  // s in q.60
    localparam int CNT_W    = 6;   // normalize shift count
    localparam int Y_W      = 31;  // log mantissa q1.30
    localparam int LOG_FRAC = 24;
    localparam int NL_W     = 30;  // -log2 s in q.24
    localparam int PROD_W   = 61;
    localparam int LQ_W     = 31;  // -2 ln s in q.24
    localparam int RT_W     = 62;  // radicand of sqrt(4s)
    localparam int R_W      = 31;
    localparam int GR_W     = 40;  // radicand of sqrt(lq << 8)
    localparam int G_W      = 20;
    localparam int P_W      = 51;
    localparam int NUM_W    = 52;
    localparam int DEN_W    = 35;
    localparam int Q_W      = 17;

    localparam logic [30:0]    TWO_LN2_Q30 = 31'd1488522236;
    localparam logic [Q_W-1:0] POS_LIMIT   = 17'd32767;
    localparam logic [Q_W-1:0] NEG_LIMIT   = 17'd32768;

    typedef struct packed {
        logic [15:0] uniform_a;
        logic [15:0] uniform_b;
    } t_in;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
        logic               clipped;
    } t_out;

    // side data that rides along the cell chain
    typedef struct packed {
        logic             v;
        logic             n1;
        logic             n2;
        logic [M_W-1:0]   m1;
        logic [M_W-1:0]   m2;
        logic [CNT_W-1:0] cnt;
        logic [R_W-1:0]   r;
    } t_side;

endpackage

// ===== sv/gaussian_polar_sampler_top.sv =====
// gaussian polar sampler
// a new pair can enter while earlier ones are in the chain; each gives two samples out, and
// the one-sample output port sets the sustained rate; a rejected pair leaves a bubble and gives nothing
// the cell chain advances while its tail is empty or the spare pair slot is free,
// so the input stall depends on registered state only
// reset: synchronous active low, clears stage valid bits, the pair buffer and spare slot
module gaussian_polar_sampler_top #(
    parameter int UNIFORM_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  gps_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output gps_pkg::t_out o_out_data
);
    import gps_pkg::*;

    // chain layout
    localparam int NORM_N  = CNT_W;
    localparam int LOG_N   = LOG_FRAC;
    localparam int SQR_N   = R_W;
    localparam int SQG_N   = G_W;
    localparam int DIV_N   = Q_W;
    localparam int ST_S    = 2;
    localparam int ST_LOG0 = ST_S + NORM_N + 1;
    localparam int ST_R    = ST_S + SQR_N + 1;
    localparam int ST_NL   = ST_S + NORM_N + LOG_N + 1;
    localparam int ST_LQ   = ST_NL + 2;
    localparam int ST_G    = ST_LQ + SQG_N;
    localparam int ST_MUL  = ST_G + 1;
    localparam int ST_NUM  = ST_MUL + 1;
    localparam int LAST    = ST_NUM + DIV_N;

    // uniform sample to sign and |v| in q.30
    function automatic logic [M_W:0] to_v(logic [UNIFORM_BITS-1:0] u);
        logic [UNIFORM_BITS-1:0]     half;
        logic [UNIFORM_BITS-1:0]     m;
        logic [UNIFORM_BITS+M_W-1:0] w;
        logic                        neg;
        half = {1'b1, {(UNIFORM_BITS-1){1'b0}}};
        if (u >= half) begin
            m   = u - half;
            neg = 1'b0;
        end else begin
            m   = half - u;
            neg = 1'b1;
        end
        w = {m, {M_W{1'b0}}} >> UNIFORM_BITS;
        return {neg, w[M_W-1:0]};
    endfunction

    // quotient to saturated q5.11
    function automatic t_out fmt(logic [Q_W-1:0] q, logic neg, logic lst);
        t_out        o;
        logic [Q_W-1:0] mag;
        logic        clip;
        logic [15:0] t;
        if (!neg) begin
            clip = q > POS_LIMIT;
            mag  = clip ? POS_LIMIT : q;
        end else begin
            clip = q > NEG_LIMIT;
            mag  = clip ? NEG_LIMIT : q;
        end
        t         = mag[15:0];
        o.sample  = neg ? (~t + 16'd1) : t;
        o.last    = lst;
        o.clipped = clip;
        return o;
    endfunction

    logic en;
    logic pair_free;
    logic rej;
    logic take;
    logic done;

    t_side r_side [0:LAST];
    t_side n_side [0:LAST];

    logic [M_W:0]    va, vb;
    logic [SQ_W-1:0] r_sq1, r_sq2;
    logic [SQ_W:0]   ssum;
    logic [S_W-1:0]  r_s;

    // normalize cells
    logic [S_W-1:0]   norm_x [0:NORM_N];
    logic [CNT_W-1:0] norm_c [0:NORM_N];
    // log2 fraction cells
    logic [Y_W-1:0]      log_y [0:LOG_N];
    logic [LOG_FRAC-1:0] log_f [0:LOG_N];
    // sqrt(4s) cells
    logic [RT_W-1:0] sr_x [0:SQR_N];
    logic [RT_W-1:0] sr_r [0:SQR_N];
    // sqrt(lq << 8) cells
    logic [GR_W-1:0] sg_x [0:SQG_N];
    logic [GR_W-1:0] sg_r [0:SQG_N];
    // divide cells, one lane per sample
    logic [NUM_W-1:0] d1_n [0:DIV_N];
    logic [Q_W-1:0]   d1_q [0:DIV_N];
    logic [NUM_W-1:0] d2_n [0:DIV_N];
    logic [Q_W-1:0]   d2_q [0:DIV_N];

    logic [NL_W-1:0]   r_nl;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W:0]   lq_sum;
    logic [LQ_W-1:0]   r_lq;
    logic [P_W-1:0]    r_p1, r_p2;
    logic [NUM_W-1:0]  r_num1, r_num2;

    // output pair buffer
    logic r_pv;
    logic r_idx;
    t_out r_o0, r_o1;
    // spare pair slot, filled while the buffer is still busy
    logic r_kv;
    t_out r_k0, r_k1;
    t_out f0, f1;

    // handshake: chain moves unless the tail holds a pair and the spare slot is taken
    assign take       = en && r_side[LAST].v;
    assign done       = r_pv && r_idx && !i_out_stall;
    assign pair_free  = !r_pv || done;
    assign en         = !r_side[LAST].v || !r_kv;
    assign o_in_stall = !en;

    assign va = to_v(UNIFORM_BITS'(i_in_data.uniform_a));
    assign vb = to_v(UNIFORM_BITS'(i_in_data.uniform_b));

    // s = v1^2 + v2^2, reject zero and s >= 1
    assign ssum = {1'b0, r_sq1} + {1'b0, r_sq2};
    assign rej  = (ssum == '0) || (ssum[SQ_W:S_W] != '0);

    always_comb begin
        n_side[0].v   = i_in_valid;
        n_side[0].n1  = va[M_W];
        n_side[0].n2  = vb[M_W];
        n_side[0].m1  = va[M_W-1:0];
        n_side[0].m2  = vb[M_W-1:0];
        n_side[0].cnt = '0;
        n_side[0].r   = '0;
        for (int k = 1; k <= LAST; k++) begin
            n_side[k] = r_side[k-1];
            if (k == ST_S) begin
                n_side[k].v = r_side[k-1].v & ~rej;
            end
            if (k == ST_LOG0) begin
                n_side[k].cnt = norm_c[NORM_N];
            end
            if (k == ST_R) begin
                n_side[k].r = sr_r[SQR_N][R_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                r_side[k].v <= 1'b0;
            end
        end else if (en) begin
            r_side <= n_side;
        end
    end

    // front stages and the scalar steps between cell groups
    assign lq_sum = {1'b0, r_prod} + ((PROD_W+1)'(1) << 29);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq1  <= SQ_W'(r_side[0].m1) * SQ_W'(r_side[0].m1);
            r_sq2  <= SQ_W'(r_side[0].m2) * SQ_W'(r_side[0].m2);
            r_s    <= ssum[S_W-1:0];
            // -log2 s = (60 - e) - frac, with 60 - e = cnt + 1
            r_nl   <= (NL_W'({1'b0, r_side[ST_NL-1].cnt} + 7'd1) << LOG_FRAC)
                      - NL_W'(log_f[LOG_N]);
            r_prod <= PROD_W'(r_nl) * PROD_W'(TWO_LN2_Q30);
            r_lq   <= lq_sum[30 +: LQ_W];
            r_p1   <= P_W'(r_side[ST_G].m1) * P_W'(sg_r[SQG_N][G_W-1:0]);
            r_p2   <= P_W'(r_side[ST_G].m2) * P_W'(sg_r[SQG_N][G_W-1:0]);
            // round half up: add den / 2 = 8r
            r_num1 <= NUM_W'(r_p1) + NUM_W'({r_side[ST_MUL].r, 3'b000});
            r_num2 <= NUM_W'(r_p2) + NUM_W'({r_side[ST_MUL].r, 3'b000});
        end
    end

    // normalize s to bit 59, then log2 fraction by repeated squaring
    assign norm_x[0] = r_s;
    assign norm_c[0] = '0;

    for (genvar i = 0; i < NORM_N; i++) begin : g_norm
        gps_norm_cell #(
            .SH(1 << (NORM_N - 1 - i))
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (norm_x[i]),
            .i_cnt (norm_c[i]),
            .o_x   (norm_x[i+1]),
            .o_cnt (norm_c[i+1])
        );
    end

    assign log_y[0] = norm_x[NORM_N][S_W-1 -: Y_W];
    assign log_f[0] = '0;

    for (genvar i = 0; i < LOG_N; i++) begin : g_log
        gps_log_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_y    (log_y[i]),
            .i_frac (log_f[i]),
            .o_y    (log_y[i+1]),
            .o_frac (log_f[i+1])
        );
    end

    // r = sqrt(4s), runs beside the log cells
    assign sr_x[0] = {r_s, 2'b00};
    assign sr_r[0] = '0;

    for (genvar i = 0; i < SQR_N; i++) begin : g_sqr
        gps_sqrt_cell #(
            .W      (RT_W),
            .BITPOS (RT_W - 2 - 2*i)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (sr_x[i]),
            .i_r   (sr_r[i]),
            .o_x   (sr_x[i+1]),
            .o_r   (sr_r[i+1])
        );
    end

    // g = sqrt(-2 ln s) in q.16
    assign sg_x[0] = {1'b0, r_lq, 8'h00};
    assign sg_r[0] = '0;

    for (genvar i = 0; i < SQG_N; i++) begin : g_sqg
        gps_sqrt_cell #(
            .W      (GR_W),
            .BITPOS (GR_W - 2 - 2*i)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (sg_x[i]),
            .i_r   (sg_r[i]),
            .o_x   (sg_x[i+1]),
            .o_r   (sg_r[i+1])
        );
    end

    // |x| = (m*g + 8r) / 16r, one quotient bit per cell
    assign d1_n[0] = r_num1;
    assign d1_q[0] = '0;
    assign d2_n[0] = r_num2;
    assign d2_q[0] = '0;

    for (genvar i = 0; i < DIV_N; i++) begin : g_div
        gps_div_cell #(
            .SH(DIV_N - 1 - i)
        ) u_lane1 (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (d1_n[i]),
            .i_den ({r_side[ST_NUM+i].r, 4'h0}),
            .i_q   (d1_q[i]),
            .o_num (d1_n[i+1]),
            .o_q   (d1_q[i+1])
        );
        gps_div_cell #(
            .SH(DIV_N - 1 - i)
        ) u_lane2 (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (d2_n[i]),
            .i_den ({r_side[ST_NUM+i].r, 4'h0}),
            .i_q   (d2_q[i]),
            .o_num (d2_n[i+1]),
            .o_q   (d2_q[i+1])
        );
    end

    // formatted pair at the tail of the chain
    assign f0 = fmt(d1_q[DIV_N], r_side[LAST].n1, 1'b0);
    assign f1 = fmt(d2_q[DIV_N], r_side[LAST].n2, 1'b1);

    // pair buffer: first sample, then the one marked last
    // a pair that arrives while the buffer is busy waits in the spare slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_idx <= 1'b0;
            r_kv  <= 1'b0;
        end else begin
            if (take && pair_free) begin
                r_pv  <= 1'b1;
                r_idx <= 1'b0;
            end else if (done && r_kv) begin
                r_idx <= 1'b0;
            end else if (done) begin
                r_pv <= 1'b0;
            end else if (r_pv && !i_out_stall) begin
                r_idx <= 1'b1;
            end
            if (take && !pair_free) begin
                r_kv <= 1'b1;
            end else if (done) begin
                r_kv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && pair_free) begin
            r_o0 <= f0;
            r_o1 <= f1;
        end else if (done && r_kv) begin
            r_o0 <= r_k0;
            r_o1 <= r_k1;
        end
        if (take && !pair_free) begin
            r_k0 <= f0;
            r_k1 <= f1;
        end
    end

    assign o_out_valid = r_pv;
    assign o_out_data  = r_idx ? r_o1 : r_o0;

endmodule

// ===== sv/gps_norm_cell.sv =====
// one normalize step: shift left by SH when the top SH bits are clear
// depends on gps_pkg
module gps_norm_cell #(
    parameter int SH = 1
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [gps_pkg::S_W-1:0]   i_x,
    input  logic [gps_pkg::CNT_W-1:0] i_cnt,
    output logic [gps_pkg::S_W-1:0]   o_x,
    output logic [gps_pkg::CNT_W-1:0] o_cnt
);
    import gps_pkg::*;

    logic [S_W-1:0]   n_x;
    logic [CNT_W-1:0] n_cnt;

    always_comb begin
        if (i_x[S_W-1 -: SH] == '0) begin
            n_x   = i_x << SH;
            n_cnt = i_cnt + CNT_W'(SH);
        end else begin
            n_x   = i_x;
            n_cnt = i_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x   <= n_x;
            o_cnt <= n_cnt;
        end
    end

endmodule

// ===== sv/gps_log_cell.sv =====
// one fraction bit of log2: square the mantissa, renormalize
// depends on gps_pkg
module gps_log_cell (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [gps_pkg::Y_W-1:0]      i_y,
    input  logic [gps_pkg::LOG_FRAC-1:0] i_frac,
    output logic [gps_pkg::Y_W-1:0]      o_y,
    output logic [gps_pkg::LOG_FRAC-1:0] o_frac
);
    import gps_pkg::*;

    logic [2*Y_W-1:0] sq;
    logic [Y_W:0]     t;

    always_comb begin
        sq = (2*Y_W)'(i_y) * (2*Y_W)'(i_y);
        t  = sq[2*Y_W-1:Y_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (t[Y_W]) begin
                o_y    <= t[Y_W:1];
                o_frac <= {i_frac[LOG_FRAC-2:0], 1'b1};
            end else begin
                o_y    <= t[Y_W-1:0];
                o_frac <= {i_frac[LOG_FRAC-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== sv/gps_sqrt_cell.sv =====
// one digit of a restoring integer square root
// depends on gps_pkg for nothing but house style
module gps_sqrt_cell #(
    parameter int W      = 40,
    parameter int BITPOS = 38
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_r,
    output logic [W-1:0] o_x,
    output logic [W-1:0] o_r
);
    import gps_pkg::*;

    localparam logic [W-1:0] BITV = W'(1) << BITPOS;

    logic [W-1:0] t;

    assign t = i_r + BITV;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_x >= t) begin
                o_x <= i_x - t;
                o_r <= (i_r >> 1) + BITV;
            end else begin
                o_x <= i_x;
                o_r <= i_r >> 1;
            end
        end
    end

endmodule

// ===== sv/gps_div_cell.sv =====
// one quotient bit of a restoring divide, weight 2^SH
// depends on gps_pkg
module gps_div_cell #(
    parameter int SH = 0
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [gps_pkg::NUM_W-1:0] i_num,
    input  logic [gps_pkg::DEN_W-1:0] i_den,
    input  logic [gps_pkg::Q_W-1:0]   i_q,
    output logic [gps_pkg::NUM_W-1:0] o_num,
    output logic [gps_pkg::Q_W-1:0]   o_q
);
    import gps_pkg::*;

    logic [NUM_W-1:0] d;

    assign d = NUM_W'(i_den) << SH;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_num >= d) begin
                o_num <= i_num - d;
                o_q   <= {i_q[Q_W-2:0], 1'b1};
            end else begin
                o_num <= i_num;
                o_q   <= {i_q[Q_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== sv/gps_checker.sv =====
// port-level checks on the gaussian polar sampler output channel
// depends on gps_pkg and gaussian_polar_sampler_top_assert.svh
`include "gaussian_polar_sampler_top_assert.svh"

module gps_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input gps_pkg::t_out o_out_data
);
    import gps_pkg::*;

    // a stalled sample holds
    `GPS_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled sample changed")

    // the first sample of a pair is followed at once by its partner
    `GPS_ASSERT_NXT(a_pair_next, o_out_valid && !i_out_stall && !o_out_data.last, o_out_valid && o_out_data.last, "second sample of pair missing")

    // a clipped sample sits at a range limit
    `GPS_ASSERT_IMP(a_clip_limit, o_out_valid && o_out_data.clipped, o_out_data.sample == 16'sh7fff || o_out_data.sample == 16'sh8000, "clipped sample off limit")

endmodule

bind gaussian_polar_sampler_top gps_checker u_gps_checker (.*);

// ===== dv/tb_gaussian_polar_sampler_top.sv =====
// testbench for the gaussian polar sampler: random and directed uniform pairs,
// samples checked against a bit-exact fixed-point predictor
// depends on gps_pkg and gaussian_polar_sampler_top
`timescale 1ns / 100ps

module tb_gaussian_polar_sampler_top;
    import gps_pkg::*;

    localparam int UB       = 16;
    localparam int N_RANDOM = 1700;
    localparam int LATENCY  = 75;
    localparam int WD_LIMIT = 20000;
    localparam int HOLD_LEN = 400;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_stall;
    t_in   i_in_data;
    logic  o_out_valid;
    logic  i_out_stall;
    t_out  o_out_data;

    gaussian_polar_sampler_top #(.UNIFORM_BITS(UB)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    t_in  pending_pairs[$];
    t_out expected_samples[$];
    int   n_errors = 0;
    bit   hold_req;     // asks the receiver for one long hold-off
    int   idle_cycles = 0;

    // integer square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // -log2(s / 2^60) in q.24
    function automatic logic [63:0] neg_log2_q24(input logic [63:0] s);
        int unsigned e;
        logic [63:0] y;
        logic [63:0] frac;
        e = 0;
        frac = 0;
        for (int k = 63; k >= 0; k--) begin
            if (s[k]) begin
                e = k;
                break;
            end
        end
        y = (e <= 30) ? (s << (30 - e)) : (s >> (e - 30));
        for (int k = 0; k < 24; k++) begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd2 << 30)) begin
                y = y >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'd60 << 24) - (64'(e) << 24) - frac;
    endfunction

    function automatic t_out scale_sample(input logic [63:0] m, input bit neg,
                                          input logic [63:0] g, input logic [63:0] r,
                                          input bit is_last);
        logic [63:0] den;
        logic [63:0] mag;
        t_out o;
        den = r << 4;
        mag = (m * g + (den >> 1)) / den;
        o.clipped = 1'b0;
        o.last = is_last;
        if (!neg && mag > 32767) begin
            mag = 32767;
            o.clipped = 1'b1;
        end else if (neg && mag > 32768) begin
            mag = 32768;
            o.clipped = 1'b1;
        end
        o.sample = neg ? -16'(mag) : 16'(mag);
        return o;
    endfunction

    // polar method: a pair inside the unit circle yields two samples
    task automatic predict_pair(input t_in p);
        logic [63:0] m1, m2, s, lq, g, r;
        bit n1, n2;
        n1 = p.uniform_a < 16'h8000;
        n2 = p.uniform_b < 16'h8000;
        m1 = n1 ? 64'(16'h8000 - p.uniform_a) : 64'(p.uniform_a - 16'h8000);
        m2 = n2 ? 64'(16'h8000 - p.uniform_b) : 64'(p.uniform_b - 16'h8000);
        m1 = m1 << (31 - UB);
        m2 = m2 << (31 - UB);
        s = m1 * m1 + m2 * m2;
        if (s == 0 || s >= (64'd1 << 60)) return;
        lq = (neg_log2_q24(s) * 64'(TWO_LN2_Q30) + (64'd1 << 29)) >> 30;
        g = isqrt64(lq << 8);
        r = isqrt64(s << 2);
        expected_samples.push_back(scale_sample(m1, n1, g, r, 1'b0));
        expected_samples.push_back(scale_sample(m2, n2, g, r, 1'b1));
    endtask

    function automatic t_in mk_pair(input logic [15:0] a, input logic [15:0] b);
        t_in p;
        p.uniform_a = a;
        p.uniform_b = b;
        return p;
    endfunction

    // sender: random gap after each transaction
    int gap_cnt;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
            gap_cnt    <= 0;
        end else if (i_in_valid && o_in_stall) begin
            // hold payload while stalled
        end else if (gap_cnt > 0) begin
            i_in_valid <= 1'b0;
            gap_cnt    <= gap_cnt - 1;
        end else if (pending_pairs.size() > 0) begin
            t_in p;
            int  gap;
            p = pending_pairs.pop_front();
            predict_pair(p);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 2) == 0) gap = 0;
            i_in_valid <= 1'b1;
            i_in_data  <= p;
            gap_cnt    <= gap;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // receiver: random stall per sample, plus one long hold-off on request
    int stall_cnt;
    int hold_cnt;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_cnt   <= 0;
            hold_cnt    <= 0;
        end else if (hold_req && hold_cnt == 0 && stall_cnt >= 0) begin
            hold_cnt    <= HOLD_LEN;
            i_out_stall <= 1'b1;
        end else if (hold_cnt > 1) begin
            hold_cnt    <= hold_cnt - 1;
        end else begin
            if (hold_cnt == 1) hold_cnt <= -1;
            if (stall_cnt > 0) begin
                stall_cnt   <= stall_cnt - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (o_out_valid && !i_out_stall)
                    stall_cnt <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
            end
        end
    end

    // result check, sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_samples.size() == 0) begin
                $error("unexpected sample %0d", o_out_data.sample);
                n_errors++;
            end else begin
                t_out e;
                e = expected_samples.pop_front();
                if (o_out_data.sample !== e.sample) begin
                    $error("sample: expected %0d actual %0d", e.sample, o_out_data.sample);
                    n_errors++;
                end
                if (o_out_data.last !== e.last) begin
                    $error("last: expected %0b actual %0b", e.last, o_out_data.last);
                    n_errors++;
                end
                if (o_out_data.clipped !== e.clipped) begin
                    $error("clipped: expected %0b actual %0b", e.clipped,
                           o_out_data.clipped);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("tb_gaussian_polar_sampler_top: FAIL");
            $finish;
        end
    end

    initial begin
        logic [15:0] a, b;
        hold_req    = 0;
        i_rst_n     = 1'b0;

        // directed: center (s zero), corners (rejected), axes, near the rim
        pending_pairs.push_back(mk_pair(16'h8000, 16'h8000));
        pending_pairs.push_back(mk_pair(16'h0000, 16'h0000));
        pending_pairs.push_back(mk_pair(16'hFFFF, 16'hFFFF));
        pending_pairs.push_back(mk_pair(16'h0000, 16'h8000));
        pending_pairs.push_back(mk_pair(16'h8000, 16'h0000));
        pending_pairs.push_back(mk_pair(16'h0001, 16'h8000));
        pending_pairs.push_back(mk_pair(16'h8000, 16'hFFFF));
        pending_pairs.push_back(mk_pair(16'hFFFF, 16'h8000));
        pending_pairs.push_back(mk_pair(16'h8001, 16'h8000));
        pending_pairs.push_back(mk_pair(16'h7FFF, 16'h8000));
        pending_pairs.push_back(mk_pair(16'h8001, 16'h7FFF));
        pending_pairs.push_back(mk_pair(16'hA000, 16'h6000));
        pending_pairs.push_back(mk_pair(16'h2000, 16'hE000));
        pending_pairs.push_back(mk_pair(16'h5555, 16'hAAAA));
        pending_pairs.push_back(mk_pair(16'h1000, 16'h8000));
        pending_pairs.push_back(mk_pair(16'hDA82, 16'h257E));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_RANDOM; k++) begin
            case ($urandom_range(0, 9))
                0: begin        // tiny magnitudes near the center
                    a = 16'h8000 + 16'($urandom_range(0, 8)) - 16'd4;
                    b = 16'h8000 + 16'($urandom_range(0, 8)) - 16'd4;
                end
                1: begin        // uniform over the full range
                    a = 16'($urandom_range(0, 65535));
                    b = 16'($urandom_range(0, 65535));
                end
                default: begin
                    a = 16'($urandom);
                    b = 16'($urandom);
                end
            endcase
            pending_pairs.push_back(mk_pair(a, b));
            if (k == N_RANDOM / 3) begin
                wait (pending_pairs.size() < 200);
                hold_req = 1;
                @(posedge i_clk);
                @(posedge i_clk);
                hold_req = 0;
            end
        end

        wait (pending_pairs.size() == 0 && !(i_in_valid && o_in_stall));
        @(posedge i_clk);
        wait (expected_samples.size() == 0);
        repeat (2 * LATENCY) @(posedge i_clk);

        if (n_errors == 0 && expected_samples.size() == 0)
            $display("tb_gaussian_polar_sampler_top: PASS");
        else
            $display("tb_gaussian_polar_sampler_top: FAIL");
        $finish;
    end

endmodule
